/* hw/rtl/mks_pkg.sv */
// ----------------------------------------------------------------------------
// Keypad scanner package
// Shared types and constants for the 4x4 matrix keypad scanner.
// ----------------------------------------------------------------------------
package mks_pkg;

    localparam int NUM_COLUMNS = 4;
    localparam int NUM_ROWS    = 4;
    localparam int COL_W       = $clog2(NUM_COLUMNS);
    localparam int ROW_W       = $clog2(NUM_ROWS);
    localparam int KEY_W       = COL_W + ROW_W;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 16;

    typedef enum logic
    {
        CMD_SCAN     = 1'b0,
        CMD_DEBOUNCE = 1'b1
    } mks_cmd_t;

    typedef struct packed
    {
        logic [COL_W-1:0] scan_column;
        logic             held;
        logic [ROW_W-1:0] held_row;
        logic [KEY_W-1:0] key_index;
        logic             reported;
    } mks_state_t;

    typedef struct packed
    {
        logic [NUM_COLUMNS-1:0] column_drive;
        logic                   key_valid;
        logic [KEY_W-1:0]       key_value;
        logic                   busy_res;
    } mks_result_t;

endpackage

/* hw/rtl/mks_step.sv */
// ----------------------------------------------------------------------------
// Keypad scanner step
// Next-state and result logic for one scan or debounce tick.
// ----------------------------------------------------------------------------
module mks_step
(
    input  mks_pkg::mks_cmd_t                  cmd,
    input  logic [mks_pkg::NUM_ROWS-1:0]       row_levels,
    input  mks_pkg::mks_state_t                state,
    output mks_pkg::mks_state_t                state_next,
    output mks_pkg::mks_result_t               result
);
    import mks_pkg::*;

    logic             found;
    logic [ROW_W-1:0] hit_row;
    logic             valid;

    always_comb
    begin
        found   = 1'b0;
        hit_row = '0;
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            if (!row_levels[r])
            begin
                found   = 1'b1;
                hit_row = ROW_W'(r);
            end
        end
    end

    always_comb
    begin
        state_next = state;
        valid      = 1'b0;
        case (cmd)
            CMD_SCAN:
            begin
                if (!state.held)
                begin
                    if (found)
                    begin
                        state_next.held      = 1'b1;
                        state_next.held_row  = hit_row;
                        state_next.key_index = {hit_row, state.scan_column};
                    end
                    else
                    begin
                        state_next.scan_column = state.scan_column + COL_W'(1);
                    end
                end
            end
            CMD_DEBOUNCE:
            begin
                if (state.held)
                begin
                    if (!row_levels[state.held_row])
                    begin
                        if (!state.reported)
                        begin
                            state_next.reported = 1'b1;
                            valid               = 1'b1;
                        end
                    end
                    else
                    begin
                        state_next.held     = 1'b0;
                        state_next.reported = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = state;
            end
        endcase
    end

    always_comb
    begin
        result.column_drive = NUM_COLUMNS'(1) << state_next.scan_column;
        result.key_valid    = valid;
        result.key_value    = valid ? ~state_next.key_index : '0;
        result.busy_res     = state_next.held;
    end

endmodule

/* hw/rtl/matrix_keypad_scanner.sv */
// ----------------------------------------------------------------------------
// Matrix keypad scanner
// 4x4 keypad scanner with debounce, one result transfer per tick transfer.
// ----------------------------------------------------------------------------
// Each tick transfer on the slave side yields exactly one result transfer on
// the master side. The block takes one tick per clock cycle while the master
// side accepts results. A tick is held in the input register while the
// single-pass step logic reads and writes the scanner state, and its result
// is captured in the result register, from which it transfers. A
// waiting result holds the input register, and the slave side stalls only
// when both registers are full. Column 0 is driven from reset, and the column
// drive in each result is the one in force after that tick.
// ----------------------------------------------------------------------------
module matrix_keypad_scanner
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mks_pkg::S_TDATA_W-1:0]   s_tdata,  // [3:0] row_levels, [7:4] zero
    input  logic                            s_tuser,  // [0] cmd
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mks_pkg::M_TDATA_W-1:0]   m_tdata,  // [3:0] column_drive,
                                                      // [7:4] key_value,
                                                      // [8] busy_res, [15:9] zero
    output logic                            m_tuser   // [0] key_valid
);
    import mks_pkg::*;

    logic                in_valid_reg;
    logic                in_valid_next;
    mks_cmd_t            in_cmd_reg;
    logic [NUM_ROWS-1:0] in_rows_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    mks_result_t         out_reg;
    mks_state_t          state_reg;
    mks_state_t          state_next;
    mks_result_t         step_result;
    logic                advance;
    logic                load_in;
    logic                step_fire;

    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign load_in   = s_tvalid && s_tready;
    assign step_fire = in_valid_reg && advance;

    always_comb
    begin
        if (load_in)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (step_fire)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    mks_step u_step
    (
        .cmd        (in_cmd_reg),
        .row_levels (in_rows_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (step_fire)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            in_cmd_reg  <= mks_cmd_t'(s_tuser);
            in_rows_reg <= s_tdata[NUM_ROWS-1:0];
        end
        if (step_fire)
            out_reg <= step_result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.key_valid;
    assign m_tdata  = M_TDATA_W'({out_reg.busy_res, out_reg.key_value, out_reg.column_drive});

    a_reported_needs_held: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.reported |-> state_reg.held)
        else $error("reported set without a held key");

    a_valid_implies_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tdata[8])
        else $error("key reported while not busy");

    a_value_zero_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[7:4] == 4'd0))
        else $error("key value not zero without a report");

    a_drive_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $onehot(m_tdata[3:0]))
        else $error("column drive not one-hot");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !step_fire |=> $stable(state_reg))
        else $error("state changed without a step");

endmodule
